/* hw/rtl/spadu_pkg.sv */
// ----------------------------------------------------------------------------
// spadu_pkg
// Shared types and constants for the operand stack unit: operation and
// status codes, result kinds and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package spadu_pkg;

    localparam int WORD_W       = 32;
    localparam int DEPTH_W      = 7;
    localparam int MIN_OPERANDS = 2;
    localparam int DIV_STEP_W   = 5;

    // last quotient-bit iteration of the restoring divider
    localparam logic [DIV_STEP_W-1:0] DIV_LAST = 5'd31;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_ADD  = 2'd1,
        OP_DIV  = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // what the commit does to the stack
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_PUSH = 2'd1,
        KIND_ADD  = 2'd2,
        KIND_DIV  = 2'd3
    } kind_t;

    typedef struct packed {
        logic    load;       // capture the incoming item
        logic    decide;     // capture the second operand
        logic    start_div;  // seed the divider
        logic    div_step;   // one quotient bit
        logic    commit;     // update stack, load result register
        kind_t   kind;
        status_t status;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic short_stack;
        logic full;
        logic div_zero;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

/* hw/rtl/spadu_ram.sv */
// ----------------------------------------------------------------------------
// spadu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spadu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/spadu_ctrl.sv */
// ----------------------------------------------------------------------------
// spadu_ctrl
// Instruction sequencer: takes one item, classifies it against the stack
// state, runs the divider when needed and commits once the result register
// is free.
// ----------------------------------------------------------------------------
module spadu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  spadu_pkg::dp_stat_t  stat,
    output spadu_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_DIV    = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    spadu_pkg::kind_t    kind_reg, kind_next;
    spadu_pkg::status_t  status_reg, status_next;

    // classify the item and sequence the work
    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.kind    = kind_reg;
        cmd.status  = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide  = 1'b1;
                kind_next   = spadu_pkg::KIND_NONE;
                status_next = spadu_pkg::ST_OK;
                state_next  = S_FINISH;
                case (stat.op)
                    spadu_pkg::OP_PUSH:
                    begin
                        if (stat.full)
                        begin
                            status_next = spadu_pkg::ST_FULL;
                        end
                        else
                        begin
                            kind_next = spadu_pkg::KIND_PUSH;
                        end
                    end
                    spadu_pkg::OP_ADD:
                    begin
                        if (stat.short_stack)
                        begin
                            status_next = spadu_pkg::ST_SHORT;
                        end
                        else
                        begin
                            kind_next = spadu_pkg::KIND_ADD;
                        end
                    end
                    spadu_pkg::OP_DIV:
                    begin
                        if (stat.short_stack)
                        begin
                            status_next = spadu_pkg::ST_SHORT;
                        end
                        else if (stat.div_zero)
                        begin
                            status_next = spadu_pkg::ST_DIVZERO;
                        end
                        else
                        begin
                            kind_next     = spadu_pkg::KIND_DIV;
                            cmd.start_div = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    default:
                    begin
                        kind_next = spadu_pkg::KIND_NONE;
                    end
                endcase
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and decision registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            kind_reg   <= spadu_pkg::KIND_NONE;
            status_reg <= spadu_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            status_reg <= status_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);

endmodule

/* hw/rtl/spadu_dp.sv */
// ----------------------------------------------------------------------------
// spadu_dp
// Stack datapath: cached top-of-stack register over a RAM of lower entries,
// entry count, adder, restoring divider and the result register.
// ----------------------------------------------------------------------------
module spadu_dp #(
    parameter int STACK_DEPTH = 64,
    localparam int CW = $clog2(STACK_DEPTH + 1),
    localparam int AW = $clog2(STACK_DEPTH)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  spadu_pkg::ctrl_cmd_t                   cmd,
    output spadu_pkg::dp_stat_t                    stat,
    input  logic [1:0]                             op,
    input  logic signed [spadu_pkg::WORD_W-1:0]    value,
    input  logic                                   rsp_stall,
    output logic                                   rsp_valid,
    output logic [1:0]                             status,
    output logic signed [spadu_pkg::WORD_W-1:0]    top_value,
    output logic [spadu_pkg::DEPTH_W-1:0]          depth_now
);

    localparam int W = spadu_pkg::WORD_W;

    spadu_pkg::op_t              op_reg;
    logic [W-1:0]                value_reg;
    logic [W-1:0]                top_reg, top_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [W-1:0]                b_reg;

    logic [W-1:0]                rem_reg, quo_reg, dvs_reg;
    logic                        neg_reg;
    logic [spadu_pkg::DIV_STEP_W-1:0] step_reg;

    logic                        rsp_valid_reg;
    logic [1:0]                  status_reg;
    logic [W-1:0]                top_out_reg;
    logic [spadu_pkg::DEPTH_W-1:0] depth_reg;

    logic [CW-1:0]               count_m1, count_m2;
    logic                        ram_we;
    logic [W-1:0]                ram_rdata;
    logic [W-1:0]                b_mag, a_mag, quotient;
    logic [W:0]                  rem_sh, diff;
    logic [CW+spadu_pkg::DEPTH_W-1:0] depth_ext;

    // lower stack entries; top lives in top_reg
    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign ram_we   = cmd.commit && (cmd.kind == spadu_pkg::KIND_PUSH)
                      && (count_reg != '0);

    spadu_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_m1[AW-1:0]),
        .wdata (top_reg),
        .raddr (count_m2[AW-1:0]),
        .rdata (ram_rdata)
    );

    // status toward the controller
    assign stat.op          = op_reg;
    assign stat.short_stack = (count_reg < CW'(spadu_pkg::MIN_OPERANDS));
    assign stat.full        = (count_reg >= CW'(STACK_DEPTH));
    assign stat.div_zero    = (top_reg == '0);
    assign stat.div_done    = (step_reg == spadu_pkg::DIV_LAST);
    assign stat.out_free    = !rsp_valid_reg || !rsp_stall;

    // capture the item and the second operand
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= spadu_pkg::op_t'(op);
            value_reg <= value;
        end
        if (cmd.decide)
        begin
            b_reg <= ram_rdata;
        end
    end

    // restoring divider on magnitudes, one quotient bit per step
    assign b_mag  = ram_rdata[W-1] ? (W'(0) - ram_rdata) : ram_rdata;
    assign a_mag  = top_reg[W-1] ? (W'(0) - top_reg) : top_reg;
    assign rem_sh = {rem_reg, quo_reg[W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            rem_reg  <= '0;
            quo_reg  <= b_mag;
            dvs_reg  <= a_mag;
            neg_reg  <= ram_rdata[W-1] ^ top_reg[W-1];
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!diff[W])
            begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
            step_reg <= step_reg + 1'b1;
        end
    end

    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

    // next stack top and count at commit
    always_comb
    begin
        top_next   = top_reg;
        count_next = count_reg;
        case (cmd.kind)
            spadu_pkg::KIND_PUSH:
            begin
                top_next   = value_reg;
                count_next = count_reg + CW'(1);
            end
            spadu_pkg::KIND_ADD:
            begin
                top_next   = b_reg + top_reg;
                count_next = count_m1;
            end
            spadu_pkg::KIND_DIV:
            begin
                top_next   = quotient;
                count_next = count_m1;
            end
            default:
            begin
                top_next   = top_reg;
                count_next = count_reg;
            end
        endcase
    end

    assign depth_ext = {{spadu_pkg::DEPTH_W{1'b0}}, count_next};

    // stack registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            top_reg <= top_next;
        end
    end

    // result register: load on commit, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg  <= cmd.status;
            top_out_reg <= (count_next == '0) ? '0 : top_next;
            depth_reg   <= depth_ext[spadu_pkg::DEPTH_W-1:0];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign top_value = top_out_reg;
    assign depth_now = depth_reg;

endmodule

/* hw/rtl/stack_push_add_div_unit.sv */
// Push, add, no-op and rejected items pass through the decide and finish
//   states after the input transfer; divide also runs the divide state,
//   the 32 iterations of the one-bit-per-cycle restoring divider.
// Items are taken one at a time; the next is accepted once the result is
//   committed, which waits while the result register is stalled.
// Reset (rst_n, async low) empties the stack and the result register; the RAM is not cleared.
// ----------------------------------------------------------------------------
// stack_push_add_div_unit
// Operand stack of signed 32-bit words executing push, add and divide, one
// result per instruction with status, new top and depth.
// ----------------------------------------------------------------------------
module stack_push_add_div_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  logic [1:0]                          op,
    input  logic signed [spadu_pkg::WORD_W-1:0] value,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [1:0]                          status,
    output logic signed [spadu_pkg::WORD_W-1:0] top_value,
    output logic [spadu_pkg::DEPTH_W-1:0]       depth_now
);

    spadu_pkg::ctrl_cmd_t cmd;
    spadu_pkg::dp_stat_t  stat;

    // sequencer
    spadu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // stack, arithmetic and result register
    spadu_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .op        (op),
        .value     (value),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .status    (status),
        .top_value (top_value),
        .depth_now (depth_now)
    );

endmodule

/* hw/rtl/spadu_checker.sv */
// ----------------------------------------------------------------------------
// spadu_checker
// Port-level checks on the operand stack unit, bound to the top level.
// ----------------------------------------------------------------------------
module spadu_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cmd_valid,
    input logic                                cmd_stall,
    input logic                                rsp_valid,
    input logic                                rsp_stall,
    input logic [1:0]                          status,
    input logic signed [spadu_pkg::WORD_W-1:0] top_value,
    input logic [spadu_pkg::DEPTH_W-1:0]       depth_now
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status)
            && $stable(top_value) && $stable(depth_now))
        else $error("stalled result changed");

    // one item in flight: the cycle after a transfer the input is stalled
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("second item taken while one is in flight");

    // no result appears in the cycle after a transfer
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> !$rose(rsp_valid))
        else $error("result appeared too early");

    // a too-short stack shows fewer than two entries
    a_short_depth: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == spadu_pkg::ST_SHORT) |-> depth_now < 7'd2)
        else $error("too-short status with a deep stack");

endmodule

bind stack_push_add_div_unit spadu_checker u_spadu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .top_value (top_value),
    .depth_now (depth_now)
);

/* dv/stack_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_result_checker
// Watches the instruction and result channels of the operand stack unit,
// keeps its own copy of the stack to work out the status, top and depth that
// each accepted instruction must produce, and compares every accepted result
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module stack_result_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    input  logic                                cmd_stall,
    input  logic [1:0]                          op,
    input  logic signed [spadu_pkg::WORD_W-1:0] value,
    input  logic                                rsp_valid,
    input  logic                                rsp_stall,
    input  logic [1:0]                          status,
    input  logic signed [spadu_pkg::WORD_W-1:0] top_value,
    input  logic [spadu_pkg::DEPTH_W-1:0]       depth_now,
    output int                                  mismatches,
    output int                                  pending
);

    typedef struct packed {
        spadu_pkg::status_t                  st;
        logic signed [spadu_pkg::WORD_W-1:0] top;
        logic [spadu_pkg::DEPTH_W-1:0]       depth;
    } stack_result_t;

    logic signed [spadu_pkg::WORD_W-1:0] model_words [STACK_DEPTH];
    int                                  model_fill;
    stack_result_t                       expected_results [$];
    stack_result_t                       oldest;

    // print one line per problem and count it
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // signed divide, truncating toward zero; most negative / -1 wraps
    function automatic logic signed [spadu_pkg::WORD_W-1:0] trunc_quotient(
        input logic signed [spadu_pkg::WORD_W-1:0] num,
        input logic signed [spadu_pkg::WORD_W-1:0] den
    );
        logic [spadu_pkg::WORD_W-1:0] num_mag;
        logic [spadu_pkg::WORD_W-1:0] den_mag;
        logic [spadu_pkg::WORD_W-1:0] quo_mag;
        num_mag = num[spadu_pkg::WORD_W-1] ? -num : num;
        den_mag = den[spadu_pkg::WORD_W-1] ? -den : den;
        quo_mag = num_mag / den_mag;
        return (num[spadu_pkg::WORD_W-1] ^ den[spadu_pkg::WORD_W-1]) ?
               $signed(-quo_mag) : $signed(quo_mag);
    endfunction

    // execute one instruction on the shadow stack and return its result
    function automatic stack_result_t exec_stack_op(
        input spadu_pkg::op_t                      code,
        input logic signed [spadu_pkg::WORD_W-1:0] operand
    );
        stack_result_t                       res;
        logic signed [spadu_pkg::WORD_W-1:0] rhs;
        logic signed [spadu_pkg::WORD_W-1:0] lhs;
        res.st = spadu_pkg::ST_OK;
        case (code) inside
            spadu_pkg::OP_PUSH:
            begin
                if (model_fill >= STACK_DEPTH)
                    res.st = spadu_pkg::ST_FULL;
                else
                begin
                    model_words[model_fill] = operand;
                    model_fill++;
                end
            end
            spadu_pkg::OP_ADD, spadu_pkg::OP_DIV:
            begin
                if (model_fill < spadu_pkg::MIN_OPERANDS)
                    res.st = spadu_pkg::ST_SHORT;
                else
                begin
                    rhs = model_words[model_fill-1];
                    lhs = model_words[model_fill-2];
                    if (code == spadu_pkg::OP_ADD)
                    begin
                        model_words[model_fill-2] = lhs + rhs;
                        model_fill--;
                    end
                    else if (rhs == 0)
                        res.st = spadu_pkg::ST_DIVZERO;
                    else
                    begin
                        model_words[model_fill-2] = trunc_quotient(lhs, rhs);
                        model_fill--;
                    end
                end
            end
            default: ;
        endcase
        res.top   = (model_fill == 0) ? '0 : model_words[model_fill-1];
        res.depth = spadu_pkg::DEPTH_W'(model_fill);
        return res;
    endfunction

    // predict on each instruction transfer, compare on each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_fill = 0;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
                expected_results.push_back(exec_stack_op(spadu_pkg::op_t'(op), value));
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result status=%0d top=%0d depth=%0d",
                                              status, top_value, depth_now));
                else
                begin
                    oldest = expected_results.pop_front();
                    if (status !== oldest.st)
                        report_mismatch($sformatf("status expected %0d got %0d",
                                                  oldest.st, status));
                    if (top_value !== oldest.top)
                        report_mismatch($sformatf("top_value expected %0d got %0d",
                                                  oldest.top, top_value));
                    if (depth_now !== oldest.depth)
                        report_mismatch($sformatf("depth_now expected %0d got %0d",
                                                  oldest.depth, depth_now));
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

/* dv/tb_stack_push_add_div_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stack_push_add_div_unit
// Drives push, add, divide and no-op instructions into the operand stack
// unit: a directed run through the corner cases, a fill to overflow and a
// drain to underflow, then random segments biased toward filling, draining
// or mixing. The sender idles in bursts, the receiver stalls on its own
// pattern including one long hold-off; a checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_stack_push_add_div_unit;

    localparam int  CLK_PERIOD  = 10;
    localparam int  STACK_DEPTH = 64;
    localparam int  ITEM_COUNT  = 600;
    localparam int  DRAIN_WAIT  = 40;
    localparam real TIMEOUT_NS  = 5_000_000.0;

    localparam logic signed [spadu_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [spadu_pkg::WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    // segment flavors of the random part
    typedef enum int { SEG_FILL, SEG_DRAIN, SEG_MIXED } seg_kind_t;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                cmd_valid = 1'b0;
    logic                                cmd_stall;
    logic [1:0]                          op        = spadu_pkg::OP_PUSH;
    logic signed [spadu_pkg::WORD_W-1:0] value     = '0;
    logic                                rsp_valid;
    logic                                rsp_stall = 1'b0;
    logic [1:0]                          status;
    logic signed [spadu_pkg::WORD_W-1:0] top_value;
    logic [spadu_pkg::DEPTH_W-1:0]       depth_now;

    int mismatches;
    int pending;
    int issued     = 0;
    int burst_left = 0;

    stack_push_add_div_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .op       (op),
        .value    (value),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .status   (status),
        .top_value(top_value),
        .depth_now(depth_now)
    );

    stack_result_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .op        (op),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .top_value (top_value),
        .depth_now (depth_now),
        .mismatches(mismatches),
        .pending   (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // offer one instruction and hold it until the transfer; idle between bursts
    task automatic issue_instr(input spadu_pkg::op_t code,
                               input logic signed [spadu_pkg::WORD_W-1:0] word);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cmd_valid <= 1'b1;
        op        <= code;
        value     <= word;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        issued++;
    endtask

    // operand mix: extremes, small values around zero, anything
    function automatic logic signed [spadu_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9)) inside
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return -1;
            [3:5]:   return $signed($urandom_range(0, 6)) - 3;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic spadu_pkg::op_t pick_op(input seg_kind_t seg);
        int roll;
        roll = $urandom_range(0, 99);
        case (seg)
            SEG_FILL:  return spadu_pkg::op_t'((roll < 85) ? spadu_pkg::OP_PUSH :
                              (roll < 93) ? spadu_pkg::OP_ADD : spadu_pkg::OP_DIV);
            SEG_DRAIN: return spadu_pkg::op_t'((roll < 15) ? spadu_pkg::OP_PUSH :
                              (roll < 55) ? spadu_pkg::OP_ADD :
                              (roll < 95) ? spadu_pkg::OP_DIV : spadu_pkg::OP_NOP);
            default:   return spadu_pkg::op_t'((roll < 45) ? spadu_pkg::OP_PUSH :
                              (roll < 70) ? spadu_pkg::OP_ADD :
                              (roll < 95) ? spadu_pkg::OP_DIV : spadu_pkg::OP_NOP);
        endcase
    endfunction

    // reset, stimulus and verdict
    initial
    begin
        seg_kind_t seg;
        int        span;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // too-short and no-op on an empty stack
        issue_instr(spadu_pkg::OP_ADD, WORD_MAX);
        issue_instr(spadu_pkg::OP_DIV, WORD_MIN);
        issue_instr(spadu_pkg::OP_NOP, -1);
        issue_instr(spadu_pkg::OP_PUSH, 7);
        issue_instr(spadu_pkg::OP_ADD, '0);
        issue_instr(spadu_pkg::OP_DIV, '0);
        // divide by zero leaves both operands, then add them
        issue_instr(spadu_pkg::OP_PUSH, 0);
        issue_instr(spadu_pkg::OP_DIV, 5);
        issue_instr(spadu_pkg::OP_ADD, 0);
        // quotient overflow wraps to the most negative value
        issue_instr(spadu_pkg::OP_PUSH, WORD_MIN);
        issue_instr(spadu_pkg::OP_PUSH, -1);
        issue_instr(spadu_pkg::OP_DIV, 0);
        issue_instr(spadu_pkg::OP_PUSH, WORD_MAX);
        issue_instr(spadu_pkg::OP_ADD, 0);
        // truncation toward zero with mixed signs
        issue_instr(spadu_pkg::OP_PUSH, -7);
        issue_instr(spadu_pkg::OP_PUSH, 2);
        issue_instr(spadu_pkg::OP_DIV, 0);
        // add wraps past the most positive value
        issue_instr(spadu_pkg::OP_PUSH, WORD_MAX);
        issue_instr(spadu_pkg::OP_PUSH, 1);
        issue_instr(spadu_pkg::OP_ADD, 0);
        issue_instr(spadu_pkg::OP_PUSH, -2);
        issue_instr(spadu_pkg::OP_DIV, 0);
        issue_instr(spadu_pkg::OP_NOP, WORD_MAX);

        // push past full, then pop down to too-short
        repeat (STACK_DEPTH + 6)
            issue_instr(spadu_pkg::OP_PUSH, pick_word());
        repeat (STACK_DEPTH + 6)
            issue_instr(spadu_pkg::op_t'(($urandom_range(0, 1) == 0) ?
                        spadu_pkg::OP_ADD : spadu_pkg::OP_DIV), pick_word());

        // random segments until the item budget is spent
        while (issued < ITEM_COUNT)
        begin
            seg  = seg_kind_t'($urandom_range(0, 2));
            span = $urandom_range(10, 80);
            repeat (span)
                issue_instr(pick_op(seg), pick_word());
        end
        cmd_valid <= 1'b0;

        // wait for outstanding results, then let stray output show up
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // receiver stall pattern with one long hold-off
    initial
    begin
        int mode;
        int span;
        int seg_count;
        seg_count = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (seg_count == 3)
            begin
                rsp_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            seg_count++;
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                case (mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 9) < 3);
                    2:       rsp_stall <= ($urandom_range(0, 9) < 7);
                    default: rsp_stall <= ~rsp_stall;
                endcase
                @(posedge clk);
            end
        end
    end

    // end a hung run
    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule

/* stack_push_add_div_unit.f */
hw/rtl/spadu_pkg.sv
hw/rtl/spadu_ram.sv
hw/rtl/spadu_ctrl.sv
hw/rtl/spadu_dp.sv
hw/rtl/stack_push_add_div_unit.sv
hw/rtl/spadu_checker.sv
dv/stack_result_checker.sv
dv/tb_stack_push_add_div_unit.sv
